FILE: design/mmet_pkg.sv
// Shared types and constants of the multi-motor encoder tracker.
`default_nettype none
package mmet_pkg;

  localparam int unsigned ID_W      = 11;
  localparam int unsigned ANGLE_W   = 13;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned RATE_W    = 14;
  localparam int unsigned FC_W      = 4;
  localparam int unsigned ID_REGS   = 4;
  localparam int unsigned ID_SEL_W  = 2;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CAL_LAST  = 10;

  localparam logic [ID_W-1:0] ID_RESET [ID_REGS] = '{11'd513, 11'd514, 11'd515, 11'd516};

  // unwrap thresholds and one full turn, on the 15-bit signed angle difference
  localparam logic signed [14:0] WRAP_HI  = 15'sd5000;
  localparam logic signed [14:0] WRAP_LO  = -15'sd5000;
  localparam logic signed [14:0] COUNTS15 = 15'sd8192;

  // degrees: total * 360 / 8192, truncated toward zero
  localparam logic signed [40:0] DEG_MUL  = 41'sd360;
  localparam logic signed [40:0] DEG_BIAS = 41'sd8191;

  typedef struct packed {
    logic                      hit;
    logic [1:0]                motor;
    logic                      cal;
    logic signed [SPEED_W-1:0] speed;
    logic signed [RATE_W-1:0]  rate;
    logic [31:0]               turns;
    logic [31:0]               total;
  } mmet_s1_t;

endpackage
`default_nettype wire

FILE: design/mmet_ram.sv
// Small synchronous RAM, one write and one read port, valid bits and write-to-read bypass.
`default_nettype none
module mmet_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [W-1:0]     mem_q;
  logic [W-1:0]     byp_data;
  logic             byp_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q    <= mem[raddr];
      byp_data <= wdata;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      byp_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        byp_q <= we && (waddr == raddr);
        vld_q <= vld[raddr];
      end
    end
  end

  assign rdata = byp_q ? byp_data : (vld_q ? mem_q : '0);

endmodule
`default_nettype wire

FILE: design/mmet_unwrap.sv
// Angle unwrap, turn count, total count and running ring sum update.
`default_nettype none
module mmet_unwrap #(
  parameter int unsigned SUM_W = 18
) (
  input  logic [12:0]       ang,
  input  logic [12:0]       off,
  input  logic [12:0]       last,
  input  logic [31:0]       turns,
  input  logic [SUM_W-1:0]  sum,
  input  logic [13:0]       ring_old,
  output logic [13:0]       rate,
  output logic [31:0]       turns_next,
  output logic [31:0]       total,
  output logic [SUM_W-1:0]  sum_next
);
  import mmet_pkg::*;

  logic signed [14:0] diff;
  logic signed [14:0] rate15;

  always_comb begin
    diff = $signed({2'b00, ang}) - $signed({2'b00, last});
    priority if (diff > WRAP_HI) begin
      turns_next = turns - 32'd1;
      rate15     = diff - COUNTS15;
    end else if (diff < WRAP_LO) begin
      turns_next = turns + 32'd1;
      rate15     = diff + COUNTS15;
    end else begin
      turns_next = turns;
      rate15     = diff;
    end
    rate     = rate15[13:0];
    total    = {turns_next[18:0], 13'b0} + {19'b0, ang} - {19'b0, off};
    sum_next = sum - {{(SUM_W-14){ring_old[13]}}, ring_old}
                   + {{(SUM_W-14){rate[13]}}, rate};
  end

endmodule
`default_nettype wire

FILE: design/mmet_scale.sv
// Degree scaling and ring mean: multiply stage, then the output register.
`default_nettype none
module mmet_scale #(
  parameter int unsigned SUM_W      = 18,
  parameter int unsigned RING_DEPTH = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mmet_pkg::mmet_s1_t  in_info,
  input  logic [SUM_W-1:0]    in_sum,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_user,  // id_matched, motor_index[1:0], calibrating
  output logic [135:0]        out_data   // speed_out, raw_rate, turn_count, total_count,
                                         // total_degrees, filtered_rate
);
  import mmet_pkg::*;

  localparam int unsigned DIV_SH = SUM_W + 5;
  localparam logic [DIV_SH:0] RECIP =
    (DIV_SH+1)'(((64'd1 << DIV_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  logic                     v2;
  mmet_s1_t                 info2;
  logic signed [40:0]       degp;
  logic [SUM_W+DIV_SH:0]    qp;
  logic                     sneg;
  logic                     s2_load;
  logic                     o_load;
  logic [SUM_W-1:0]         abs_sum;
  logic signed [40:0]       deg_b;
  logic [13:0]              quo;
  logic [13:0]              filt;
  logic                     live;

  assign s2_load  = in_valid && in_ready;
  assign o_load   = v2 && (!out_valid || out_ready);
  assign in_ready = !v2 || o_load;
  assign abs_sum  = in_sum[SUM_W-1] ? (~in_sum + 1'b1) : in_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_load) begin
        v2 <= 1'b1;
      end else if (o_load) begin
        v2 <= 1'b0;
      end
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      info2 <= in_info;
      degp  <= $signed(in_info.total) * DEG_MUL;
      qp    <= abs_sum * RECIP;
      sneg  <= in_sum[SUM_W-1];
    end
  end

  // truncation toward zero: bias negatives before the shift
  always_comb begin
    deg_b = degp + (degp[40] ? DEG_BIAS : 41'sd0);
    quo   = qp[DIV_SH +: 14];
    filt  = sneg ? (~quo + 1'b1) : quo;
    live  = info2.hit && !info2.cal;
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_user <= {info2.cal, info2.motor, info2.hit};
      out_data <= live ? {filt, deg_b[40:13], info2.total, info2.turns,
                          info2.rate, info2.speed} : '0;
    end
  end

endmodule
`default_nettype wire

FILE: design/multi_motor_encoder_tracker_unit.sv
// Top level of the multi-motor encoder tracker: config, id match, state memories, pipeline.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: frame_id, angle_word, speed_word
//  m_      | out | m_tvalid/m_tready  | tuser: flags and motor; tdata: numeric results
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (motor id registers 0..3)
//
// Throughput is one item per cycle while m_tready keeps the output draining. The rate
// is set by the per-motor record RAM read-modify-write: read at acceptance, written
// back when the item leaves stage 1, with a bypass when the next item hits the same motor.
// Reset (rst, synchronous) restores the id registers and clears all per-motor state;
// RAM valid bits make unwritten entries read as zero, so no clearing pass is needed.
// Each stage holds while the stage after it is full, so s_tready stays high while a
// result waits at the output, until all three stages are occupied.
`default_nettype none
module multi_motor_encoder_tracker_unit #(
  parameter int unsigned RING_DEPTH  = 5,
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  logic         clk,
  input  logic         rst,
  // feedback frames
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // frame_id[10:0], angle_word[23:11], speed_word[39:24]
  // results
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [3:0]   m_tuser,   // id_matched[0], motor_index[2:1], calibrating[3]
  output logic [135:0] m_tdata,   // speed_out[15:0], raw_rate[29:16], turn_count[61:30],
                                  // total_count[93:62], total_degrees[121:94],
                                  // filtered_rate[135:122]
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [10:0]  cfg_data
);
  import mmet_pkg::*;

  // only as many motors as there are id registers can ever match
  localparam int unsigned NMOT    = (MOTOR_COUNT < ID_REGS) ? MOTOR_COUNT : ID_REGS;
  localparam int unsigned MI_W    = (NMOT > 1) ? $clog2(NMOT) : 1;
  localparam int unsigned PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned RING_N  = NMOT * RING_DEPTH;
  localparam int unsigned RING_AW = (RING_N > 1) ? $clog2(RING_N) : 1;
  // ring sum holds RING_DEPTH signed 14-bit rates
  localparam int unsigned SUM_W   = 15 + $clog2(RING_DEPTH);
  // record layout: offset, last angle, turns, ring sum (low to high)
  localparam int unsigned REC_W   = 58 + SUM_W;

  // ---------------- configuration ----------------
  logic [ID_W-1:0] id_reg [ID_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_reg <= ID_RESET;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(ID_REGS))) begin
      id_reg[cfg_index[ID_SEL_W-1:0]] <= cfg_data;
    end
  end

  // ---------------- stage 0: accept, match, issue reads ----------------
  logic [ID_W-1:0]    fid;
  logic [12:0]        ang;
  logic [15:0]        spd;
  logic               accept;
  logic               hit;
  logic [MI_W-1:0]    mi;
  logic               cal;
  logic [FC_W-1:0]    fc [NMOT];
  logic [PTR_W-1:0]   ptr [NMOT];
  logic [FC_W-1:0]    fc_sel;
  logic [PTR_W-1:0]   ptr_sel;
  logic [PTR_W-1:0]   ptr_next;
  logic [RING_AW-1:0] ring_addr;

  assign fid    = s_tdata[10:0];
  assign ang    = s_tdata[23:11];
  assign spd    = s_tdata[39:24];
  assign accept = s_tvalid && s_tready;

  // lowest-numbered motor wins on duplicate ids
  always_comb begin
    hit = 1'b0;
    mi  = '0;
    for (int i = NMOT - 1; i >= 0; i--) begin
      if (id_reg[i] == fid) begin
        hit = 1'b1;
        mi  = MI_W'(i);
      end
    end
  end

  always_comb begin
    fc_sel    = fc[mi];
    ptr_sel   = ptr[mi];
    cal       = hit && (fc_sel <= FC_W'(CAL_LAST));
    ptr_next  = (ptr_sel == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
    ring_addr = RING_AW'(RING_AW'(mi) * RING_AW'(RING_DEPTH) + RING_AW'(ptr_sel));
  end

  // calibration count and ring pointer depend only on themselves, so they advance
  // here and never need forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NMOT; i++) begin
        fc[i]  <= '0;
        ptr[i] <= '0;
      end
    end else if (accept && hit) begin
      if (cal) begin
        fc[mi] <= fc_sel + 1'b1;
      end else begin
        ptr[mi] <= ptr_next;
      end
    end
  end

  // ---------------- stage 1: modify and write back ----------------
  logic               s1_valid;
  logic               s1_hit;
  logic [MI_W-1:0]    s1_mi;
  logic               s1_cal;
  logic [12:0]        s1_ang;
  logic [15:0]        s1_spd;
  logic [RING_AW-1:0] s1_raddr;
  logic               s1_adv;
  logic               sc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit   <= hit;
      s1_mi    <= mi;
      s1_cal   <= cal;
      s1_ang   <= ang;
      s1_spd   <= spd;
      s1_raddr <= ring_addr;
    end
  end

  assign s1_adv   = s1_valid && sc_ready;
  assign s_tready = !s1_valid || sc_ready;

  logic [REC_W-1:0] rec_rdata;
  logic [REC_W-1:0] rec_wdata;
  logic [13:0]      ring_rdata;
  logic [12:0]      rd_off;
  logic [12:0]      rd_last;
  logic [31:0]      rd_turns;
  logic [SUM_W-1:0] rd_sum;
  logic [13:0]      rate;
  logic [31:0]      turns_next;
  logic [31:0]      total;
  logic [SUM_W-1:0] sum_next;
  mmet_s1_t         s1_info;

  assign rd_off   = rec_rdata[12:0];
  assign rd_last  = rec_rdata[25:13];
  assign rd_turns = rec_rdata[57:26];
  assign rd_sum   = rec_rdata[58 +: SUM_W];

  // per-motor record: read at accept, written when the item leaves stage 1
  mmet_ram #(
    .W     (REC_W),
    .DEPTH (NMOT),
    .AW    (MI_W)
  ) u_rec_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (s1_adv && s1_hit),
    .waddr (s1_mi),
    .wdata (rec_wdata),
    .re    (accept),
    .raddr (mi),
    .rdata (rec_rdata)
  );

  // rate ring, one row of RING_DEPTH entries per motor
  mmet_ram #(
    .W     (14),
    .DEPTH (RING_N),
    .AW    (RING_AW)
  ) u_ring_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (s1_adv && s1_hit && !s1_cal),
    .waddr (s1_raddr),
    .wdata (rate),
    .re    (accept),
    .raddr (ring_addr),
    .rdata (ring_rdata)
  );

  mmet_unwrap #(
    .SUM_W (SUM_W)
  ) u_unwrap (
    .ang        (s1_ang),
    .off        (rd_off),
    .last       (rd_last),
    .turns      (rd_turns),
    .sum        (rd_sum),
    .ring_old   (ring_rdata),
    .rate       (rate),
    .turns_next (turns_next),
    .total      (total),
    .sum_next   (sum_next)
  );

  // calibration frames only relatch offset and last angle
  always_comb begin
    if (s1_cal) begin
      rec_wdata = {rd_sum, rd_turns, s1_ang, s1_ang};
    end else begin
      rec_wdata = {sum_next, turns_next, s1_ang, rd_off};
    end
    s1_info.hit   = s1_hit;
    s1_info.motor = 2'(s1_mi);
    s1_info.cal   = s1_cal;
    s1_info.speed = s1_spd;
    s1_info.rate  = rate;
    s1_info.turns = turns_next;
    s1_info.total = total;
  end

  // ---------------- stages 2 and 3: scaling and output register ----------------
  mmet_scale #(
    .SUM_W      (SUM_W),
    .RING_DEPTH (RING_DEPTH)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (sc_ready),
    .in_info   (s1_info),
    .in_sum    (sum_next),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_user  (m_tuser),
    .out_data  (m_tdata)
  );

  // ---------------- checks ----------------
  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    accept && hit |-> fc[mi] <= FC_W'(CAL_LAST + 1))
    else $error("calibration count past its limit");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    accept && hit |-> ptr[mi] <= PTR_W'(RING_DEPTH - 1))
    else $error("ring pointer out of range");

  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input stalled with stage 1 empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented right after reset");

endmodule
`default_nettype wire

FILE: tb/mmet_track_tb_pkg.sv
// Scoreboard for the multi-motor encoder tracker: predicts each reading and checks the outputs.
package mmet_track_tb_pkg;
  import mmet_pkg::*;

  localparam int RING_DEPTH   = 5;
  localparam int MOTORS       = 4;
  localparam int WRAP_LIMIT   = 5000;
  localparam int TURN_COUNTS  = 8192;
  localparam int DEG_PER_TURN = 360;
  localparam int REPORT_MAX   = 10;

  // one expected reading, fields at the block's widths
  typedef struct {
    bit        hit;
    bit [1:0]  motor;
    bit        cal;
    bit [15:0] speed;
    bit [13:0] rate;
    bit [31:0] turns;
    bit [31:0] total;
    bit [27:0] deg;
    bit [13:0] filt;
  } reading_t;

  class encoder_track_sb;
    bit [ID_W-1:0] id_reg [ID_REGS];
    int unsigned   cal_seen [MOTORS];
    bit [12:0]     offset [MOTORS];
    bit [12:0]     last_seen [MOTORS];
    bit [31:0]     turns [MOTORS];
    int            ring [MOTORS][RING_DEPTH];
    int            ring_ptr [MOTORS];
    int            ring_sum [MOTORS];
    reading_t      awaited_readings [$];
    int            errors;
    int            frames_seen, unmatched, latches, wraps, readings_checked;

    function new();
      for (int i = 0; i < ID_REGS; i++) id_reg[i] = ID_RESET[i];
      for (int m = 0; m < MOTORS; m++) begin
        cal_seen[m]  = 0;
        offset[m]    = '0;
        last_seen[m] = '0;
        turns[m]     = '0;
        ring_ptr[m]  = 0;
        ring_sum[m]  = 0;
        for (int k = 0; k < RING_DEPTH; k++) ring[m][k] = 0;
      end
      errors = 0;
    endfunction

    function void set_id(bit [CFG_IDX_W-1:0] idx, bit [ID_W-1:0] val);
      if (idx < ID_REGS) id_reg[idx] = val;
    endfunction

    function int pending();
      return awaited_readings.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("MISMATCH %s", msg);
    endfunction

    // Unwrap one frame against the selected motor's state and queue the reading.
    function void note_frame(bit [10:0] fid, bit [12:0] ang, bit [15:0] spd);
      reading_t  r;
      int        m;
      int        d;
      int        rate;
      int        q;
      int        p;
      bit [31:0] total;
      longint    deg;
      r = '{default: 0};
      m = -1;
      frames_seen++;
      for (int i = 0; i < MOTORS; i++)
        if (m < 0 && id_reg[i] == fid) m = i;
      if (m < 0) begin
        unmatched++;
      end else begin
        r.hit   = 1'b1;
        r.motor = m[1:0];
        if (cal_seen[m] <= CAL_LAST) begin
          // still latching the zero offset
          offset[m]    = ang;
          last_seen[m] = ang;
          cal_seen[m]++;
          r.cal = 1'b1;
          latches++;
        end else begin
          d = int'(ang) - int'(last_seen[m]);
          if (d > WRAP_LIMIT) begin
            turns[m] -= 1;
            rate = d - TURN_COUNTS;
            wraps++;
          end else if (d < -WRAP_LIMIT) begin
            turns[m] += 1;
            rate = d + TURN_COUNTS;
            wraps++;
          end else begin
            rate = d;
          end
          last_seen[m] = ang;
          total = turns[m] * TURN_COUNTS + ang - offset[m];
          deg   = longint'($signed(total)) * DEG_PER_TURN / TURN_COUNTS;
          p = ring_ptr[m];
          ring_sum[m] = ring_sum[m] - ring[m][p] + rate;
          ring[m][p]  = rate;
          ring_ptr[m] = (p + 1) % RING_DEPTH;
          q = ring_sum[m] / RING_DEPTH;
          r.speed = spd;
          r.rate  = rate[13:0];
          r.turns = turns[m];
          r.total = total;
          r.deg   = deg[27:0];
          r.filt  = q[13:0];
        end
      end
      awaited_readings.push_back(r);
    endfunction

    function void compare(string nm, bit [63:0] want, bit [63:0] got);
      if (want != got)
        flag($sformatf("reading %0d %s: expected %0h, got %0h", readings_checked, nm, want, got));
    endfunction

    function void check_reading(bit [3:0] user, bit [135:0] data);
      reading_t e;
      if (awaited_readings.size() == 0) begin
        flag($sformatf("unexpected reading user=%0h data=%0h", user, data));
        return;
      end
      e = awaited_readings.pop_front();
      compare("id_matched", e.hit, user[0]);
      compare("motor_index", e.motor, user[2:1]);
      compare("calibrating", e.cal, user[3]);
      compare("speed_out", e.speed, data[15:0]);
      compare("raw_rate", e.rate, data[29:16]);
      compare("turn_count", e.turns, data[61:30]);
      compare("total_count", e.total, data[93:62]);
      compare("total_degrees", e.deg, data[121:94]);
      compare("filtered_rate", e.filt, data[135:122]);
      readings_checked++;
    endfunction
  endclass

endpackage

FILE: tb/multi_motor_encoder_tracker_unit_test.sv
// Stream-level test of multi_motor_encoder_tracker_unit against a scoreboard predictor.
module multi_motor_encoder_tracker_unit_test;
  import mmet_pkg::*;
  import mmet_track_tb_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [39:0]  s_tdata;   // frame_id[10:0], angle_word[23:11], speed_word[39:24]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [3:0]   m_tuser;   // id_matched[0], motor_index[2:1], calibrating[3]
  logic [135:0] m_tdata;   // speed_out, raw_rate, turn_count, total_count,
                           // total_degrees, filtered_rate (low bits first)
  logic         cfg_valid;
  logic         cfg_ready;
  logic [3:0]   cfg_index;
  logic [10:0]  cfg_data;

  encoder_track_sb sb;

  // stimulus-side copy of the ids and each motor's last angle, for the angle walk
  bit [10:0] cur_id [MOTORS];
  bit [12:0] walk_ang [MOTORS];

  // long receiver hold-off: main bumps the request count, the receiver serves it
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int rx_tick       = 0;

  multi_motor_encoder_tracker_unit #(
    .RING_DEPTH (RING_DEPTH),
    .MOTOR_COUNT(MOTORS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous ceiling on simulation time, so a hung run still ends.
  initial begin
    #4000000;
    $display("multi_motor_encoder_tracker_unit_test: errors");
    $finish;
  end

  // Both handshakes sampled at the edge; inputs noted before results are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_frame(s_tdata[10:0], s_tdata[23:11], s_tdata[39:24]);
      if (m_tvalid && m_tready) sb.check_reading(m_tuser, m_tdata);
    end
  end

  // Receiver: pattern from rx_tick[8:6]; a hold request overrides it until hold_left runs out.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= 80;
      m_tready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      case (rx_tick[8:6])
        3'd0, 3'd1, 3'd5: m_tready <= 1'b1;                       // no stalls
        3'd2:             m_tready <= ($urandom_range(0, 3) != 0);
        3'd3:             m_tready <= ($urandom_range(0, 3) == 0);
        3'd4:             m_tready <= rx_tick[1];                 // follows rx_tick[1]
        default:          m_tready <= (rx_tick % 5 == 0);
      endcase
    end
  end

  // Offer one frame and hold it until accepted; valid stays high for the caller.
  task automatic send_frame(input bit [10:0] fid, input bit [12:0] ang, input bit [15:0] spd);
    s_tvalid <= 1'b1;
    s_tdata  <= {spd, ang, fid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender pause until every reading is back, then a further idle margin.
  // One edge first, so the last accepted frame is already queued before counting.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input bit [3:0] idx, input bit [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_id(idx, val);
    if (idx < ID_REGS) cur_id[idx] = val;
  endtask

  // Loads all four ids; optionally also pokes out-of-range indexes, which must be ignored.
  task automatic set_ids(input bit [10:0] a, input bit [10:0] b, input bit [10:0] c,
                         input bit [10:0] d, input bit stray);
    write_reg(4'd0, a);
    if (stray) write_reg(4'd15, 11'd513);
    write_reg(4'd1, b);
    write_reg(4'd2, c);
    if (stray) write_reg(4'd4, 11'h7FF);
    write_reg(4'd3, d);
    cfg_valid <= 1'b0;
  endtask

  // Random frames: mostly known ids with an angle walk that often lands near the
  // wrap threshold, some arbitrary ids. Steady mode sends back to back.
  task automatic random_frames(input int n, input bit steady);
    int        burst_left;
    int        m;
    int        delta;
    int        tmp;
    bit [10:0] fid;
    bit [12:0] ang;
    bit [15:0] spd;
    burst_left = 0;
    repeat (n) begin
      if (!steady && burst_left == 0) begin
        idle_cycles($urandom_range(0, 6));
        burst_left = $urandom_range(1, 24);
      end
      if (!steady) burst_left--;
      m   = $urandom_range(0, MOTORS - 1);
      fid = ($urandom_range(0, 6) == 0) ? 11'($urandom_range(0, 2047)) : cur_id[m];
      case ($urandom_range(0, 9))
        0, 1:    delta = $urandom_range(0, 8191);
        2, 3:    delta = $urandom_range(4990, 5010);
        default: delta = $urandom_range(0, 900);
      endcase
      if ($urandom_range(0, 1)) delta = -delta;
      tmp = int'(walk_ang[m]) + delta;
      ang = tmp[12:0];
      walk_ang[m] = ang;
      case ($urandom_range(0, 15))
        0:       spd = 16'h8000;
        1:       spd = 16'h7FFF;
        default: spd = 16'($urandom);
      endcase
      send_frame(fid, ang, spd);
    end
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < MOTORS; i++) begin
      cur_id[i]   = ID_RESET[i];
      walk_ang[i] = '0;
    end
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset ids. Unmatched frames first: everything must read zero.
    send_frame(11'd0, 13'd0, 16'd0);
    send_frame(11'h7FF, 13'h1FFF, 16'h8000);
    // Motor 0: eleven offset latches; numeric outputs stay zero, offset ends at 100.
    send_frame(11'd513, 13'd8191, 16'h7FFF);
    send_frame(11'd513, 13'd0, 16'h8000);
    send_frame(11'd513, 13'd4096, 16'd1);
    send_frame(11'd513, 13'd1, 16'hFFFF);
    send_frame(11'd513, 13'd8190, 16'd1234);
    send_frame(11'd513, 13'd2730, 16'd0);
    send_frame(11'd513, 13'd5461, 16'd77);
    send_frame(11'd513, 13'd7000, 16'd9);
    send_frame(11'd513, 13'd12, 16'd5);
    send_frame(11'd513, 13'd300, 16'd3);
    send_frame(11'd513, 13'd100, 16'd2);
    // A first latch on motor 1 shows a nonzero motor index.
    send_frame(11'd514, 13'd4321, 16'd11);
    // Tracking: change of exactly +5000 and -5000 stays, +/-5001 and beyond wrap.
    send_frame(11'd513, 13'd5100, 16'h7FFF);  // +5000, no wrap
    send_frame(11'd513, 13'd99, 16'h8000);    // -5001, one turn up
    send_frame(11'd513, 13'd5099, 16'd0);     // +5000
    send_frame(11'd513, 13'd99, 16'd1);       // -5000
    send_frame(11'd513, 13'd5100, 16'd2);     // +5001, one turn down
    send_frame(11'd513, 13'd8191, 16'd3);     // small step to the top count
    send_frame(11'd513, 13'd0, 16'd4);        // top to zero, one turn up
    send_frame(11'd513, 13'd8191, 16'd5);     // zero to top, one turn down
    send_frame(11'd513, 13'd8191, 16'd6);     // no motion
    walk_ang[0] = 13'd8191;
    drain();

    // Extreme ids with duplicates: motor 0 beats 3 on id 0, motor 1 beats 2 on all ones.
    set_ids(11'd0, 11'h7FF, 11'h7FF, 11'd0, 1'b1);
    send_frame(11'd0, 13'd8000, 16'd10);
    send_frame(11'h7FF, 13'd4000, 16'd20);
    send_frame(11'd513, 13'd1, 16'd30);       // old id, now unmatched
    random_frames(150, 1'b0);
    drain();

    // Random ids; midway the receiver holds off while the sender keeps pushing.
    set_ids(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
            11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), 1'b0);
    random_frames(120, 1'b0);
    hold_requests = hold_requests + 1;
    random_frames(40, 1'b1);
    random_frames(90, 1'b0);
    drain();

    // Reset id values in reverse order.
    set_ids(11'd516, 11'd515, 11'd514, 11'd513, 1'b1);
    random_frames(250, 1'b0);
    drain();

    if (sb.pending() != 0) sb.flag($sformatf("%0d readings never arrived", sb.pending()));
    $display("covered %0d frames: %0d unmatched, %0d offset latches, %0d turn wraps",
             sb.frames_seen, sb.unmatched, sb.latches, sb.wraps);
    $display("four id settings incl. duplicates and ignored writes; %0d mismatches",
             sb.errors);
    if (sb.errors == 0) begin
      $display("multi_motor_encoder_tracker_unit_test: clean");
    end else begin
      $display("multi_motor_encoder_tracker_unit_test: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mmet_pkg.sv
design/mmet_ram.sv
design/mmet_unwrap.sv
design/mmet_scale.sv
design/multi_motor_encoder_tracker_unit.sv
tb/mmet_track_tb_pkg.sv
tb/multi_motor_encoder_tracker_unit_test.sv
